// ----- design/dwsp_pkg.sv -----
`default_nettype none
package dwsp_pkg;

  // ring geometry
  localparam int RING_DEPTH = 8;
  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // datapath widths
  localparam int DATA_W = 16;
  localparam int SUM_W = 17;
  localparam int OPND_W = 19;
  localparam int PROD_W = DATA_W + OPND_W;
  localparam int ACCUM_W = 48;
  localparam int ACC_W = 50;
  localparam int QUOT_W = ACCUM_W - 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT = 3'd4;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [14:0]              sum_limit;
  } cfg_t;

  // lane status toward the merge stage
  typedef struct packed {
    logic                     idle;
    logic                     done;
    logic signed [DATA_W-1:0] drive;
  } lane_res_t;

  // saturate to int16
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [QUOT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > QUOT_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -QUOT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dwsp_lane.sv -----
`default_nettype none
module dwsp_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [dwsp_pkg::DATA_W-1:0] speed,
  input  logic signed [dwsp_pkg::DATA_W-1:0] target,
  input  dwsp_pkg::cfg_t                    cfg,
  input  logic                              ack,
  output dwsp_pkg::lane_res_t               res
);
  import dwsp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FOLD  = 11'b00000000010,
    S_ERR   = 11'b00000000100,
    S_SUM   = 11'b00000001000,
    S_MUL0  = 11'b00000010000,
    S_MUL1  = 11'b00000100000,
    S_MUL2  = 11'b00001000000,
    S_ADD   = 11'b00010000000,
    S_SAT   = 11'b00100000000,
    S_DRIVE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX_X =
    $signed({{(ACC_W-ACCUM_W+1){1'b0}}, {(ACCUM_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_MIN_X = -ACC_MAX_X - ACC_W'(1);

  state_t state;

  logic signed [DATA_W-1:0]  ring [RING_DEPTH];
  logic [RING_AW-1:0]        wp;
  logic [RING_AW-1:0]        cnt;
  logic signed [DATA_W-1:0]  target_q;
  logic signed [DATA_W-1:0]  filt;
  logic signed [DATA_W-1:0]  err;
  logic signed [DATA_W-1:0]  last_err;
  logic signed [DATA_W-1:0]  prev_err;
  logic signed [SUM_W-1:0]   err_sum;
  logic signed [OPND_W-1:0]  x0;
  logic signed [OPND_W-1:0]  x1;
  logic signed [OPND_W-1:0]  x2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACCUM_W-1:0] drive_accum;
  logic signed [DATA_W-1:0]  drive;

  logic signed [SUM_W-1:0]   fold_sum;
  logic signed [SUM_W-1:0]   fold_adj;
  logic signed [SUM_W-1:0]   err_diff;
  logic signed [SUM_W+0:0]   sum_ext;
  logic signed [SUM_W+0:0]   lim;
  logic signed [SUM_W-1:0]   sum_clamp;
  logic signed [OPND_W-1:0]  err_delta;
  logic signed [OPND_W-1:0]  err_curve;
  logic signed [DATA_W-1:0]  mul_g;
  logic signed [OPND_W-1:0]  mul_x;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ACCUM_W-1:0] accum_rnd;

  // fold step: add and halve toward zero
  assign fold_sum = SUM_W'(filt) + SUM_W'(ring[cnt]);
  assign fold_adj = fold_sum + $signed({{(SUM_W-1){1'b0}}, fold_sum[SUM_W-1]});

  // error against the filtered speed
  assign err_diff = SUM_W'(target_q) - SUM_W'(filt);

  // clamped error sum for positional mode
  assign sum_ext = (SUM_W+1)'(err_sum) + (SUM_W+1)'(err);
  assign lim = $signed({3'b000, cfg.sum_limit});
  always_comb begin
    if (sum_ext > lim) begin
      sum_clamp = SUM_W'(lim);
    end else if (sum_ext < -lim) begin
      sum_clamp = SUM_W'(-lim);
    end else begin
      sum_clamp = SUM_W'(sum_ext);
    end
  end

  // difference terms
  assign err_delta = OPND_W'(err) - OPND_W'(last_err);
  assign err_curve = OPND_W'(err) - (OPND_W'(last_err) <<< 1) + OPND_W'(prev_err);

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_g = cfg.integ_gain;
        mul_x = x1;
      end
      S_MUL2: begin
        mul_g = cfg.deriv_gain;
        mul_x = x2;
      end
      default: begin
        mul_g = cfg.prop_gain;
        mul_x = x0;
      end
    endcase
  end

  // accumulator saturation to 48 bits
  always_comb begin
    if (acc > ACC_MAX_X) begin
      acc_sat = ACC_MAX_X;
    end else if (acc < ACC_MIN_X) begin
      acc_sat = ACC_MIN_X;
    end else begin
      acc_sat = acc;
    end
  end

  // divide by 256 toward zero
  assign accum_rnd = drive_accum + $signed({{(ACCUM_W-8){1'b0}}, {8{drive_accum[ACCUM_W-1]}}});

  // sequencer and lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      cnt         <= '0;
      last_err    <= '0;
      prev_err    <= '0;
      err_sum     <= '0;
      drive_accum <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ring[wp] <= speed;
            wp       <= (wp == RING_AW'(RING_DEPTH - 1)) ? '0 : wp + RING_AW'(1);
            target_q <= target;
            cnt      <= '0;
            state    <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (cnt == '0) begin
            filt <= ring[cnt];
          end else begin
            filt <= fold_adj[SUM_W-1:1];
          end
          if (cnt == RING_AW'(RING_DEPTH - 1)) begin
            state <= S_ERR;
          end else begin
            cnt <= cnt + RING_AW'(1);
          end
        end
        S_ERR: begin
          err   <= sat16(QUOT_W'(err_diff));
          state <= S_SUM;
        end
        S_SUM: begin
          if (cfg.mode == MODE_POSITIONAL) begin
            err_sum <= sum_clamp;
            x0      <= OPND_W'(err);
            x1      <= OPND_W'(sum_clamp);
            x2      <= err_delta;
            acc     <= '0;
          end else begin
            prev_err <= last_err;
            x0       <= err_delta;
            x1       <= OPND_W'(err);
            x2       <= err_curve;
            acc      <= ACC_W'(drive_accum);
          end
          last_err <= err;
          state    <= S_MUL0;
        end
        S_MUL0: begin
          prod  <= PROD_W'(mul_g) * PROD_W'(mul_x);
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= acc + ACC_W'(prod);
          prod  <= PROD_W'(mul_g) * PROD_W'(mul_x);
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + ACC_W'(prod);
          prod  <= PROD_W'(mul_g) * PROD_W'(mul_x);
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= acc + ACC_W'(prod);
          state <= S_SAT;
        end
        S_SAT: begin
          drive_accum <= acc_sat[ACCUM_W-1:0];
          state       <= S_DRIVE;
        end
        S_DRIVE: begin
          drive <= sat16(accum_rnd[ACCUM_W-1:8]);
          state <= S_DONE;
        end
        S_DONE: begin
          if (ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.idle  = (state == S_IDLE);
  assign res.done  = (state == S_DONE);
  assign res.drive = drive;

endmodule
`default_nettype wire

// ----- design/dwsp_merge.sv -----
`default_nettype none
module dwsp_merge (
  input  logic                clk,
  input  logic                rst,
  input  dwsp_pkg::lane_res_t left_res,
  input  dwsp_pkg::lane_res_t right_res,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [31:0]         out_data,
  output logic                ack
);
  import dwsp_pkg::*;

  // take both lane results once the output register is free
  assign ack = left_res.done && right_res.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ack) begin
      out_data <= {right_res.drive, left_res.drive};
    end
  end

endmodule
`default_nettype wire

// ----- design/dual_wheel_speed_pid_top.sv -----
// two-lane wheel speed pid, left and right lanes run side by side in lockstep
// a new request is taken only once both lanes are idle again; without output stalls the
//   request rate is set by the per-lane ring fold (one entry a cycle) and the shared
//   three-step gain multiplier
// reset: synchronous, clears rings, errors, sums and drive accumulators,
//   loads config defaults (positional mode, zero gains, full sum limit)
`default_nettype none
module dual_wheel_speed_pid_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_speed, right_speed, left_target, right_target
  input  logic [63:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // left_drive, right_drive
  output logic [31:0]                   m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [dwsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import dwsp_pkg::*;

  cfg_t      cfg;
  lane_res_t left_res;
  lane_res_t right_res;
  logic      start;
  logic      ack;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_POSITIONAL;
      cfg.prop_gain  <= '0;
      cfg.integ_gain <= '0;
      cfg.deriv_gain <= '0;
      cfg.sum_limit  <= 15'h7fff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:       cfg.mode       <= mode_t'(cfg_data[0]);
        CFG_PROP_GAIN:  cfg.prop_gain  <= $signed(cfg_data);
        CFG_INTEG_GAIN: cfg.integ_gain <= $signed(cfg_data);
        CFG_DERIV_GAIN: cfg.deriv_gain <= $signed(cfg_data);
        CFG_SUM_LIMIT:  cfg.sum_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // a request starts both lanes at once
  assign s_axis_tready = left_res.idle && right_res.idle;
  assign start = s_axis_tvalid && s_axis_tready;

  dwsp_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .speed  ($signed(s_axis_tdata[15:0])),
    .target ($signed(s_axis_tdata[47:32])),
    .cfg    (cfg),
    .ack    (ack),
    .res    (left_res)
  );

  dwsp_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .speed  ($signed(s_axis_tdata[31:16])),
    .target ($signed(s_axis_tdata[63:48])),
    .cfg    (cfg),
    .ack    (ack),
    .res    (right_res)
  );

  dwsp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .left_res  (left_res),
    .right_res (right_res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .ack       (ack)
  );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import dwsp_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = RING_DEPTH + 20;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_REPORTS = 100;
  localparam longint DRIVE_ACC_MAX = 64'sd140737488355327;
  localparam longint DRIVE_ACC_MIN = -DRIVE_ACC_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] right_drive;
    logic signed [DATA_W-1:0] left_drive;
  } drive_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // left_speed, right_speed, left_target, right_target
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // left_drive, right_drive
  logic [31:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_wheel_speed_pid_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // controller state mirrored per lane (0 left, 1 right)
  logic signed [DATA_W-1:0] speed_ring [2][RING_DEPTH];
  int unsigned ring_wpos [2];
  logic signed [DATA_W-1:0] last_err [2];
  logic signed [DATA_W-1:0] prev_err [2];
  logic signed [SUM_W-1:0] err_sum [2];
  logic signed [ACCUM_W-1:0] drive_acc [2];

  // mirrored configuration
  mode_t cur_mode = MODE_POSITIONAL;
  logic signed [DATA_W-1:0] kp = '0;
  logic signed [DATA_W-1:0] ki = '0;
  logic signed [DATA_W-1:0] kd = '0;
  logic [14:0] lim = 15'h7fff;

  drive_pair_t drive_expect [$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;
  int hold_count = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one lane of the speed loop: ring update, fold, pid law, drive saturation
  function automatic logic signed [DATA_W-1:0] lane_drive(input int ln,
                                                          input logic signed [DATA_W-1:0] speed,
                                                          input logic signed [DATA_W-1:0] target);
    int filt;
    longint e;
    longint s;
    longint acc;
    speed_ring[ln][ring_wpos[ln]] = speed;
    ring_wpos[ln] = (ring_wpos[ln] + 1) % RING_DEPTH;
    filt = int'(speed_ring[ln][0]);
    for (int i = 1; i < RING_DEPTH; i++) begin
      filt = (filt + int'(speed_ring[ln][i])) / 2;
    end
    e = clamp(longint'(target) - longint'(filt), -longint'(32768), longint'(32767));
    if (cur_mode == MODE_POSITIONAL) begin
      s = clamp(longint'(err_sum[ln]) + e, -longint'(lim), longint'(lim));
      err_sum[ln] = s[SUM_W-1:0];
      acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - longint'(last_err[ln]));
    end else begin
      acc = longint'(drive_acc[ln])
          + longint'(kp) * (e - longint'(last_err[ln]))
          + longint'(ki) * e
          + longint'(kd) * (e - 2 * longint'(last_err[ln]) + longint'(prev_err[ln]));
      prev_err[ln] = last_err[ln];
    end
    acc = clamp(acc, DRIVE_ACC_MIN, DRIVE_ACC_MAX);
    drive_acc[ln] = acc[ACCUM_W-1:0];
    last_err[ln] = e[DATA_W-1:0];
    return DATA_W'(clamp(acc / 256, -longint'(32768), longint'(32767)));
  endfunction

  task automatic clear_lanes();
    for (int ln = 0; ln < 2; ln++) begin
      for (int i = 0; i < RING_DEPTH; i++) speed_ring[ln][i] = '0;
      ring_wpos[ln] = 0;
      last_err[ln] = '0;
      prev_err[ln] = '0;
      err_sum[ln] = '0;
      drive_acc[ln] = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count < MAX_REPORTS) begin
      $display("%0t ns: %s got %0d want %0d", $time, what, $signed(got), $signed(want));
    end
    fail_count++;
  endtask

  // offer one request, wait for it to be taken, then predict its drives
  task automatic send_item(input logic [15:0] ls, input logic [15:0] rs,
                           input logic [15:0] lt, input logic [15:0] rt);
    drive_pair_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rt, lt, rs, ls};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p.left_drive = lane_drive(0, ls, lt);
    p.right_drive = lane_drive(1, rs, rt);
    drive_expect.push_back(p);
  endtask

  // stop offering and wait until every drive has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE: cur_mode = mode_t'(val[0]);
      CFG_PROP_GAIN: kp = val;
      CFG_INTEG_GAIN: ki = val;
      CFG_DERIV_GAIN: kd = val;
      CFG_SUM_LIMIT: lim = val[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input mode_t mode, input logic [15:0] p, input logic [15:0] i,
                            input logic [15:0] d, input logic [14:0] l);
    wait_drained();
    write_reg(CFG_MODE, {15'd0, mode});
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_SUM_LIMIT, {1'b0, l});
  endtask

  // speeds and targets: mostly moderate, some full range, some extremes
  function automatic logic [15:0] pick_field();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 16'($urandom_range(4000)) - 16'd2000;
    if (r < 90) return 16'($urandom);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // gains: mostly near unity so drives stay inside int16 often
  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom_range(1024)) - 16'd512;
    if (r < 80) return 16'($urandom);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'h0100;
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 15'($urandom_range(3000));
    if (r < 80) return 15'($urandom);
    return (r < 90) ? 15'd0 : 15'h7fff;
  endfunction

  task automatic send_random_item();
    send_item(pick_field(), pick_field(), pick_field(), pick_field());
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin : drive_check
    drive_pair_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (drive_expect.size() == 0) begin
        report_mismatch("drive with no request pending", m_axis_tdata[15:0], 16'd0);
      end else begin
        want = drive_expect.pop_front();
        if (m_axis_tdata[15:0] !== want.left_drive) begin
          report_mismatch("left_drive", m_axis_tdata[15:0], want.left_drive);
        end
        if (m_axis_tdata[31:16] !== want.right_drive) begin
          report_mismatch("right_drive", m_axis_tdata[31:16], want.right_drive);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_on && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_on) hold_count <= 0;
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // reset config, zero gains give zero drive at any input
  task automatic test_reset_defaults();
    send_item(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // positional mode at gain and limit extremes, error saturation, sum clamp
  task automatic test_positional_limits();
    set_config(MODE_POSITIONAL, 16'h0100, 16'h8000, 16'h7fff, 15'd0);
    send_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    set_config(MODE_POSITIONAL, 16'h7fff, 16'h0100, 16'h8000, 15'h7fff);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_item(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
  endtask

  // incremental mode with full error, drive accumulator grows past 32 bits
  task automatic test_incremental_growth();
    set_config(MODE_INCREMENTAL, 16'h8000, 16'h7fff, 16'hffff, 15'h7fff);
    repeat (5) send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
  endtask

  // switching from positional to incremental mode mid-stream, carrying the lane state over
  task automatic test_mode_switch();
    set_config(MODE_POSITIONAL, 16'h0100, 16'h0080, 16'h0040, 15'd1000);
    send_item(16'd300, 16'hff00, 16'd500, 16'd200);
    send_item(16'd310, 16'hff10, 16'd500, 16'd200);
    set_config(MODE_INCREMENTAL, 16'h0100, 16'h0080, 16'h0040, 15'd1000);
    send_item(16'd320, 16'hff20, 16'd400, 16'd100);
    send_item(16'd330, 16'hff30, 16'd400, 16'd100);
  endtask

  // writes to indexes past the register list change nothing
  task automatic test_unused_index();
    wait_drained();
    for (int idx = CFG_UNUSED_FIRST; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), 16'($urandom));
    end
    send_item(16'd100, 16'd200, 16'd900, 16'hfc00);
    send_item(16'd150, 16'd250, 16'd900, 16'hfc00);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    set_config(MODE_POSITIONAL, pick_gain(), pick_gain(), pick_gain(), pick_limit());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_on <= 1'b1;
    repeat (40) send_random_item();
    hold_on <= 1'b0;
    wait_drained();
  endtask

  // random phases, each with its own settings and idling pattern
  task automatic test_random_phases();
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_config(mode_t'(ph % 2), pick_gain(), pick_gain(), pick_gain(), pick_limit());
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    clear_lanes();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_positional_limits();
    test_incremental_growth();
    test_mode_switch();
    test_unused_index();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
